### rtl/fqa_pkg.sv
// shared types, operation codes and helpers for the q24.8 fixed-point alu
package fqa_pkg;

	localparam int DATA_W = 32;
	// quotient bits kept before saturation, and remainder width of the divider
	localparam int QUO_W  = DATA_W + 1;
	localparam int REM_W  = QUO_W + DATA_W + 1;

	localparam logic [3:0] CMD_ADD = 4'd0;
	localparam logic [3:0] CMD_SUB = 4'd1;
	localparam logic [3:0] CMD_MUL = 4'd2;
	localparam logic [3:0] CMD_DIV = 4'd3;
	localparam logic [3:0] CMD_INC = 4'd4;
	localparam logic [3:0] CMD_DEC = 4'd5;
	localparam logic [3:0] CMD_MIN = 4'd6;
	localparam logic [3:0] CMD_MAX = 4'd7;
	localparam logic [3:0] CMD_CMP = 4'd8;
	localparam logic [3:0] CMD_INT = 4'd9;

	typedef struct packed {
		logic [3:0]               cmd;
		logic signed [DATA_W-1:0] operand_a;
		logic signed [DATA_W-1:0] operand_b;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic                     is_equal;
		logic                     is_less;
		logic                     is_greater;
		logic                     divide_by_zero;
		logic                     overflowed;
	} out_word_t;

	// everything that rides alongside the divider
	typedef struct packed {
		logic [3:0]        cmd;
		logic [DATA_W-1:0] res;
		logic              ov;
		logic              eq;
		logic              lt;
		logic              gt;
		logic              dz;
		logic              neg;
		logic [DATA_W-1:0] ma;
		logic [DATA_W-1:0] mb;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DATA_W:0]  den;
		logic [QUO_W-1:0] quo;
		logic             big;
	} div_t;

	// saturate a 33-bit signed sum: {overflow, value}
	function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] s);
		logic [DATA_W:0] r;
		if (s[DATA_W] != s[DATA_W-1]) begin
			r = s[DATA_W] ? {1'b1, 1'b1, {(DATA_W-1){1'b0}}} : {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = {1'b0, s[DATA_W-1:0]};
		end
		return r;
	endfunction

endpackage

### rtl/fqa_front.sv
// first stage: decode, magnitudes, comparisons, simple operations, divider set-up
module fqa_front import fqa_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     valid_i,
	input  in_word_t word_i,
	output logic     valid_s1,
	output side_t    side_s1,
	output div_t     div_s1
);

	logic signed [DATA_W-1:0] a, b;
	logic [DATA_W-1:0] ma, mb, ip;
	logic [DATA_W:0]   add_s, sub_s, inc_s, dec_s, pick;
	side_t side_d;
	div_t  div_d;

	assign a = word_i.operand_a;
	assign b = word_i.operand_b;
	assign ma = a[DATA_W-1] ? (~a + 1'b1) : a;
	assign mb = b[DATA_W-1] ? (~b + 1'b1) : b;
	assign ip = ma >> FRAC_BITS;

	assign add_s = sat_sum({a[DATA_W-1], a} + {b[DATA_W-1], b});
	assign sub_s = sat_sum({a[DATA_W-1], a} - {b[DATA_W-1], b});
	assign inc_s = sat_sum({a[DATA_W-1], a} + (DATA_W+1)'(1));
	assign dec_s = sat_sum({a[DATA_W-1], a} - (DATA_W+1)'(1));

	always_comb begin
		side_d.cmd = word_i.cmd;
		side_d.eq  = (a == b);
		side_d.lt  = (a < b);
		side_d.gt  = (a > b);
		side_d.dz  = (word_i.cmd == CMD_DIV) && (mb == '0);
		side_d.neg = a[DATA_W-1] ^ b[DATA_W-1];
		side_d.ma  = ma;
		side_d.mb  = mb;
		pick = '0;
		case (word_i.cmd)
			CMD_ADD: pick = add_s;
			CMD_SUB: pick = sub_s;
			CMD_INC: pick = inc_s;
			CMD_DEC: pick = dec_s;
			CMD_MIN: pick = {1'b0, side_d.lt ? a : b};
			CMD_MAX: pick = {1'b0, side_d.gt ? a : b};
			CMD_INT: pick = {1'b0, a[DATA_W-1] ? (~ip + 1'b1) : ip};
			default: pick = '0;
		endcase
		side_d.ov  = pick[DATA_W];
		side_d.res = pick[DATA_W-1:0];
		// rounded quotient is (2*ma*2^f + mb) / (2*mb)
		div_d.rem = (REM_W'(ma) << (FRAC_BITS + 1)) + REM_W'(mb);
		div_d.den = {mb, 1'b0};
		div_d.quo = '0;
		div_d.big = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			div_s1  <= div_d;
		end
	end

endmodule

### rtl/fqa_div_step.sv
// one registered step of the restoring divider, one quotient bit per stage
module fqa_div_step import fqa_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_i,
	input  side_t side_i,
	input  div_t  div_i,
	output logic  valid_s,
	output side_t side_s,
	output div_t  div_s
);

	logic [REM_W-1:0] trial;
	div_t div_d;

	assign trial = REM_W'(div_i.den) << BIT;

	always_comb begin
		div_d = div_i;
		if (div_i.rem >= trial) begin
			if (BIT >= QUO_W) begin
				// quotient needs more bits than kept: saturates later
				div_d.big = 1'b1;
			end else begin
				div_d.rem = div_i.rem - trial;
				div_d.quo[BIT % QUO_W] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s <= side_i;
			div_s  <= div_d;
		end
	end

endmodule

### rtl/fqa_back.sv
// last two stages: magnitude product, then rounding, saturation and result select
module fqa_back import fqa_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      valid_i,
	input  side_t     side_i,
	input  div_t      div_i,
	output logic      valid_s2,
	output out_word_t word_s2
);

	logic              valid_s1;
	side_t             side_s1;
	logic [QUO_W-1:0]  quo_s1;
	logic              big_s1;
	logic [2*DATA_W-1:0] prod_s1;

	logic [2*DATA_W:0] rnd, mmag, dmag, mag;
	logic [DATA_W:0]   fin;
	out_word_t         word_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			quo_s1  <= div_i.quo;
			big_s1  <= div_i.big;
			prod_s1 <= side_i.ma * side_i.mb;
		end
	end

	assign rnd  = {1'b0, prod_s1} + ((2*DATA_W+1)'(1) << (FRAC_BITS - 1));
	assign mmag = rnd >> FRAC_BITS;
	assign dmag = big_s1 ? '1 : (2*DATA_W+1)'(quo_s1);
	assign mag  = (side_s1.cmd == CMD_MUL) ? mmag : dmag;

	// signed saturation of a sign and magnitude: {overflow, value}
	always_comb begin
		if (side_s1.neg) begin
			if (mag > (2*DATA_W+1)'(64'h8000_0000)) begin
				fin = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				fin = {1'b0, ~mag[DATA_W-1:0] + 1'b1};
			end
		end else begin
			if (mag > (2*DATA_W+1)'(64'h7fff_ffff)) begin
				fin = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
			end else begin
				fin = {1'b0, mag[DATA_W-1:0]};
			end
		end
	end

	always_comb begin
		word_d.is_equal       = side_s1.eq;
		word_d.is_less        = side_s1.lt;
		word_d.is_greater     = side_s1.gt;
		word_d.divide_by_zero = side_s1.dz;
		if ((side_s1.cmd == CMD_MUL) || ((side_s1.cmd == CMD_DIV) && !side_s1.dz)) begin
			word_d.result_value = fin[DATA_W-1:0];
			word_d.overflowed   = fin[DATA_W];
		end else begin
			word_d.result_value = side_s1.res;
			word_d.overflowed   = side_s1.ov;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s2 <= word_d;
		end
	end

endmodule

### rtl/fixed_q24_8_alu.sv
// top level of the signed q24.8 fixed-point alu pipeline
//
// input channel: in_valid / in_ready carry one word of cmd and two raw
// signed fixed-point operands. output channel: out_valid / out_ready carry
// one result word: value, compare flags, divide-by-zero and overflow.
// every input word yields exactly one output word, in order.
// from acceptance to out_valid a word passes one decode stage,
// 34 divider stages (an overflow check and one quotient bit per stage,
// set by the 33-bit quotient), a multiply stage and a rounding stage that
// is also the output register.
// throughput is one word per cycle while out_ready is not held low, the same for every operation.
// the whole pipeline advances together; when the receiver holds out_ready
// low with a word waiting, every stage holds and in_ready drops, so nothing
// is lost or repeated. bubbles stay in place while stalled.
// reset clears only the stage valid bits; the block is empty after reset.
module fixed_q24_8_alu import fqa_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	localparam int STEPS = QUO_W + 1;

	logic  en;
	logic  vld [STEPS+1];
	side_t side [STEPS+1];
	div_t  dv [STEPS+1];

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	fqa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(in_valid), .word_i(in_data),
		.valid_s1(vld[0]), .side_s1(side[0]), .div_s1(dv[0])
	);

	// overflow check first, then quotient bits from the top down
	for (genvar k = 0; k < STEPS; k++) begin : g_div
		fqa_div_step #(.BIT(QUO_W - k)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.valid_i(vld[k]), .side_i(side[k]), .div_i(dv[k]),
			.valid_s(vld[k+1]), .side_s(side[k+1]), .div_s(dv[k+1])
		);
	end

	fqa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.valid_i(vld[STEPS]), .side_i(side[STEPS]), .div_i(dv[STEPS]),
		.valid_s2(out_valid), .word_s2(out_data)
	);

endmodule

### rtl/fqa_checker.sv
// port-level checks for the fixed-point alu, bound to the top level
module fqa_checker import fqa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({out_data.is_equal, out_data.is_less, out_data.is_greater}))
		else $error("compare flags not exclusive");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |->
			(out_data.result_value == 0) && !out_data.overflowed)
		else $error("divide by zero word not cleared");

endmodule

bind fixed_q24_8_alu fqa_checker u_fqa_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

### dv/testbench.sv
// self-checking testbench for the q24.8 fixed-point alu: directed table then random words
`timescale 1ns / 100ps
module testbench;
	import fqa_pkg::*;

	localparam int FRAC = 8;
	localparam int N_RANDOM = 800;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam logic signed [31:0] MINV = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	fixed_q24_8_alu #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	typedef struct {
		logic [3:0] cmd;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit typed;
		logic signed [31:0] res;
		bit ov;
		bit dz;
	} row_t;

	out_word_t pending[$];
	int errors = 0;
	longint cycles = 0;
	bit sending_done = 1'b0;
	bit hold_rx = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] sat_mag(input bit neg, input logic [63:0] m,
		inout bit ov);
		if (neg) begin
			if (m > 64'h80000000) begin
				ov = 1'b1;
				return MINV;
			end
			return -$signed(m[31:0]);
		end
		if (m > 64'h7fffffff) begin
			ov = 1'b1;
			return MAXV;
		end
		return m[31:0];
	endfunction

	function automatic logic signed [31:0] sat64(input longint v, inout bit ov);
		if (v > longint'(MAXV)) begin
			ov = 1'b1;
			return MAXV;
		end
		if (v < longint'(MINV)) begin
			ov = 1'b1;
			return MINV;
		end
		return v[31:0];
	endfunction

	function automatic out_word_t alu_result(input in_word_t w);
		out_word_t o;
		longint a, b;
		logic [63:0] ma, mb, m;
		bit ov, neg;
		a = w.operand_a;
		b = w.operand_b;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		neg = (a < 0) != (b < 0);
		ov = 1'b0;
		o = '0;
		case (w.cmd)
			CMD_ADD: o.result_value = sat64(a + b, ov);
			CMD_SUB: o.result_value = sat64(a - b, ov);
			CMD_MUL: begin
				m = ((ma * mb) + (64'd1 << (FRAC - 1))) >> FRAC;
				o.result_value = sat_mag(neg, m, ov);
			end
			CMD_DIV: begin
				if (b == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					m = ma << FRAC;
					m = (2 * m + mb) / (2 * mb);
					o.result_value = sat_mag(neg, m, ov);
				end
			end
			CMD_INC: o.result_value = sat64(a + 1, ov);
			CMD_DEC: o.result_value = sat64(a - 1, ov);
			CMD_MIN: o.result_value = (a < b) ? w.operand_a : w.operand_b;
			CMD_MAX: o.result_value = (a > b) ? w.operand_a : w.operand_b;
			CMD_INT: begin
				m = ma >> FRAC;
				o.result_value = (a < 0) ? -$signed(m[31:0]) : m[31:0];
			end
			default: o.result_value = '0;
		endcase
		o.is_equal = a == b;
		o.is_less = a < b;
		o.is_greater = a > b;
		o.overflowed = ov;
		return o;
	endfunction

	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending.push_back(alu_result(w));
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
		if ($urandom_range(0, 2) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? MAXV : MINV;
			1: return $signed($urandom_range(0, 2047)) - 1024;
			2: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
			3: return $urandom_range(0, 1) ? 32'sd0 : 32'sd256;
			default: return $urandom;
		endcase
	endfunction

	// stimulus
	initial begin
		row_t rows[$];
		in_word_t w;
		out_word_t e;
		rows = '{
			'{CMD_ADD, MAXV, 32'sd1, 1, MAXV, 1, 0},
			'{CMD_ADD, MINV, -32'sd1, 1, MINV, 1, 0},
			'{CMD_SUB, MINV, 32'sd1, 1, MINV, 1, 0},
			'{CMD_SUB, MAXV, MINV, 1, MAXV, 1, 0},
			'{CMD_MUL, MAXV, MAXV, 1, MAXV, 1, 0},
			'{CMD_MUL, MINV, MAXV, 1, MINV, 1, 0},
			'{CMD_MUL, 32'sd384, -32'sd1, 0, 0, 0, 0},
			'{CMD_MUL, 32'sd128, 32'sd1, 0, 0, 0, 0},
			'{CMD_DIV, 32'sd256, 32'sd0, 1, 0, 0, 1},
			'{CMD_DIV, MINV, 32'sd0, 1, 0, 0, 1},
			'{CMD_DIV, MAXV, 32'sd1, 1, MAXV, 1, 0},
			'{CMD_DIV, MINV, -32'sd1, 1, MAXV, 1, 0},
			'{CMD_DIV, 32'sd256, 32'sd768, 0, 0, 0, 0},
			'{CMD_DIV, -32'sd1, MAXV, 0, 0, 0, 0},
			'{CMD_INC, MAXV, 32'sd0, 1, MAXV, 1, 0},
			'{CMD_DEC, MINV, 32'sd0, 1, MINV, 1, 0},
			'{CMD_MIN, MINV, MAXV, 1, MINV, 0, 0},
			'{CMD_MAX, MINV, MAXV, 1, MAXV, 0, 0},
			'{CMD_CMP, 32'sd5, 32'sd5, 1, 0, 0, 0},
			'{CMD_INT, MINV, 32'sd0, 1, -32'sd8388608, 0, 0},
			'{CMD_INT, -32'sd255, 32'sd0, 1, 0, 0, 0},
			'{CMD_INT, MAXV, 32'sd0, 1, 32'sd8388607, 0, 0},
			'{4'd15, -32'sd1, 32'sd1, 1, 0, 0, 0},
			'{4'd10, 32'sd0, 32'sd0, 1, 0, 0, 0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			w = '{rows[i].cmd, rows[i].a, rows[i].b};
			e = alu_result(w);
			if (rows[i].typed && (e.result_value !== rows[i].res ||
				e.overflowed !== rows[i].ov || e.divide_by_zero !== rows[i].dz)) begin
				$display("%0t table row %0d disagrees with predictor: %h vs %h", $time, i,
					rows[i].res, e.result_value);
				errors++;
			end
			send_word(w);
			idle_gap();
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			w.cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			w.operand_a = rand_operand();
			w.operand_b = ($urandom_range(0, 7) == 0) ? w.operand_a : rand_operand();
			if (n == 200) hold_rx = 1'b1;
			if (n == 400 && pending.size() != 0) begin
				// let the pipeline drain completely
				in_valid <= 1'b0;
				while (pending.size() != 0) @(posedge clk);
			end
			send_word(w);
			if (n < 200 || n > 300) idle_gap();
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				out_ready <= 1'b0;
				repeat (150) @(posedge clk);
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
			if ($urandom_range(0, 2) == 0) n = 0;
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// result check
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$display("%0t unexpected word: actual %h", $time, out_data);
				errors++;
			end else begin
				e = pending.pop_front();
				if (out_data !== e) begin
					$display("%0t expected %h %b%b%b%b%b actual %h %b%b%b%b%b", $time,
						e.result_value, e.is_equal, e.is_less, e.is_greater,
						e.divide_by_zero, e.overflowed, out_data.result_value,
						out_data.is_equal, out_data.is_less, out_data.is_greater,
						out_data.divide_by_zero, out_data.overflowed);
					errors++;
				end
			end
		end
	end

	// end of run and timeout
	initial begin
		while (!(sending_done && pending.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("fixed_q24_8_alu: mismatch");
			$finish;
		end else begin
			repeat (60) @(posedge clk);
			if (errors == 0 && pending.size() == 0) begin
				$display("fixed_q24_8_alu: match");
			end else begin
				$display("fixed_q24_8_alu: mismatch");
			end
			$finish;
		end
	end

endmodule
